### rtl/cpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clip playback clock package
// Shared item types, command codes and the control and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpc_pkg;

  // Number of clip identifier bits that carry meaning.
  localparam int ClipIdBits = 16;
  localparam int ClipW      = 16;
  localparam logic [ClipW-1:0] ClipMask =
      (ClipIdBits >= ClipW) ? {ClipW{1'b1}} : ClipW'((64'd1 << ClipIdBits) - 64'd1);

  localparam logic signed [15:0] SpeedReset = 16'sd256;
  localparam logic [16:0]        WeightOne  = 17'h10000;

  // Divider counter start values, one below the step counts: full 32-bit remainder and 16-bit blend fraction.
  localparam logic [4:0] RemSteps  = 5'd31;
  localparam logic [4:0] FracSteps = 5'd15;

  typedef enum logic [3:0] {
    OpTick        = 4'd0,
    OpPlay        = 4'd1,
    OpCrossfade   = 4'd2,
    OpPlayCurrent = 4'd3,
    OpPause       = 4'd4,
    OpResume      = 4'd5,
    OpStop        = 4'd6,
    OpResetTime   = 4'd7,
    OpSetTime     = 4'd8,
    OpSetClip     = 4'd9,
    OpSetLoop     = 4'd10
  } op_e;

  typedef struct packed {
    logic [3:0]        op;
    logic [15:0]       clip_id;
    logic              loop_request;
    logic              restart;
    logic signed [31:0] value;
    logic signed [31:0] clip_duration;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] time_out;
    logic              playing_out;
    logic              finished_out;
    logic              transitioning_out;
    logic [16:0]       blend_weight;
    logic [15:0]       source_clip_out;
    logic signed [31:0] source_time_out;
    logic              source_loop_out;
    logic [15:0]       clip_out;
    logic              loop_out;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic exec_cmd;
    logic mul;
    logic tick_add;
    logic rem_start;
    logic div_step;
    logic rem_apply;
    logic wgt_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic tick_active;
    logic need_rem;
    logic wgt_direct;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

### rtl/cpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clip playback clock controller
// Sequences one item through decode, tick arithmetic, the shared divider
// and the output register.
// ----------------------------------------------------------------------------
module cpc_ctrl
  import cpc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StDecode,
    StMul,
    StAdd,
    StRemLoad,
    StRem,
    StRemFix,
    StWgtLoad,
    StWgt,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StDecode;
        end
      end
      StDecode: begin
        if (stat_i.is_tick) begin
          state_d = stat_i.tick_active ? StMul : StWgtLoad;
        end else begin
          cmd_o.exec_cmd = 1'b1;
          state_d        = StWgtLoad;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAdd;
      end
      StAdd: begin
        cmd_o.tick_add = 1'b1;
        state_d        = stat_i.need_rem ? StRemLoad : StWgtLoad;
      end
      StRemLoad: begin
        cmd_o.rem_start = 1'b1;
        state_d         = StRem;
      end
      StRem: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StRemFix;
        end
      end
      StRemFix: begin
        cmd_o.rem_apply = 1'b1;
        state_d         = StWgtLoad;
      end
      StWgtLoad: begin
        cmd_o.wgt_start = 1'b1;
        state_d         = stat_i.wgt_direct ? StEmit : StWgt;
      end
      StWgt: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### rtl/cpc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clip playback clock datapath
// Playback and crossfade state, the speed multiplier, a shared restoring
// divider for the loop remainder and the blend weight, and the output register.
// ----------------------------------------------------------------------------
module cpc_datapath
  import cpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  in_item_t          in_item_i,
  input  logic              speed_we_i,
  input  logic signed [15:0] speed_i,
  output out_item_t         out_item_o
);

  // Architectural state.
  logic signed [15:0] speed_q, speed_d;
  logic signed [31:0] pos_q, pos_d;
  logic               playing_q, playing_d;
  logic               finished_q, finished_d;
  logic               loop_q, loop_d;
  logic [15:0]        clip_q, clip_d;
  logic [15:0]        src_clip_q, src_clip_d;
  logic signed [31:0] src_pos_q, src_pos_d;
  logic               src_loop_q, src_loop_d;
  logic signed [31:0] blen_q, blen_d;
  logic signed [31:0] belap_q, belap_d;

  // Working registers.
  in_item_t           item_q;
  logic signed [47:0] prod_q;
  logic [31:0]        dvd_q;
  logic [31:0]        rem_q;
  logic [31:0]        div_q;
  logic [15:0]        quo_q;
  logic [4:0]         cnt_q;
  logic               neg_q;
  logic               wfrac_q;
  out_item_t          out_q;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [40:0] hi;
    logic signed [40:0] lo;
    hi = 41'sd2147483647;
    lo = -41'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic signed [31:0] delta;
  logic signed [31:0] dur;
  logic [15:0]        clip_in;
  logic               blending;
  logic signed [31:0] elap_pos;
  logic signed [39:0] step;
  logic signed [31:0] pos_t;
  logic signed [31:0] src_t;
  logic signed [31:0] el_t;
  logic signed [31:0] delta_pos;
  logic               clr;

  assign delta    = item_q.value;
  assign dur      = item_q.clip_duration;
  assign clip_in  = item_q.clip_id & ClipMask;
  assign blending = (blen_q > 32'sd0) && (src_clip_q != '0);
  assign elap_pos = belap_q[31] ? 32'sd0 : belap_q;

  // Q24.24 product floored to Q24.16 is simply the upper bits.
  assign step      = prod_q[47:8];
  assign delta_pos = delta[31] ? 32'sd0 : delta;
  assign pos_t     = sat32(41'(pos_q) + 41'(step));
  assign src_t     = sat32(41'(src_pos_q) + 41'(step));
  assign el_t      = sat32(41'(belap_q) + 41'(delta_pos));

  assign stat_o.is_tick     = (item_q.op == OpTick);
  assign stat_o.tick_active = playing_q && (clip_q != '0);
  assign stat_o.need_rem    = loop_q && (dur > 32'sd0);
  assign stat_o.wgt_direct  = !blending || (elap_pos >= blen_q);
  assign stat_o.div_last    = (cnt_q == '0);

  always_comb begin
    speed_d    = speed_q;
    pos_d      = pos_q;
    playing_d  = playing_q;
    finished_d = finished_q;
    loop_d     = loop_q;
    clip_d     = clip_q;
    src_clip_d = src_clip_q;
    src_pos_d  = src_pos_q;
    src_loop_d = src_loop_q;
    blen_d     = blen_q;
    belap_d    = belap_q;
    clr        = 1'b0;

    if (speed_we_i) begin
      speed_d = speed_i;
    end

    if (cmd_i.exec_cmd) begin
      case (item_q.op)
        OpTick: begin
        end
        OpPlay: begin
          clip_d     = clip_in;
          loop_d     = item_q.loop_request;
          playing_d  = 1'b1;
          finished_d = 1'b0;
          clr        = 1'b1;
          if (item_q.restart) begin
            pos_d = '0;
          end
        end
        OpCrossfade: begin
          if ((delta <= 32'sd0) || (clip_q == '0)) begin
            clip_d     = clip_in;
            loop_d     = item_q.loop_request;
            playing_d  = 1'b1;
            finished_d = 1'b0;
            clr        = 1'b1;
            if (item_q.restart) begin
              pos_d = '0;
            end
          end else if ((clip_in == clip_q) && !item_q.restart) begin
            loop_d    = item_q.loop_request;
            playing_d = 1'b1;
          end else begin
            src_clip_d = clip_q;
            src_pos_d  = pos_q;
            src_loop_d = loop_q;
            blen_d     = delta;
            belap_d    = '0;
            clip_d     = clip_in;
            loop_d     = item_q.loop_request;
            playing_d  = 1'b1;
            finished_d = 1'b0;
            if (item_q.restart) begin
              pos_d = '0;
            end
          end
        end
        OpPlayCurrent: begin
          playing_d  = (clip_q != '0);
          finished_d = 1'b0;
          clr        = 1'b1;
          if (item_q.restart) begin
            pos_d = '0;
          end
        end
        OpPause: begin
          playing_d = 1'b0;
        end
        OpResume: begin
          if (clip_q != '0) begin
            playing_d  = 1'b1;
            finished_d = 1'b0;
          end
        end
        OpStop: begin
          playing_d  = 1'b0;
          finished_d = 1'b1;
          pos_d      = '0;
          clr        = 1'b1;
        end
        OpResetTime: begin
          pos_d      = '0;
          finished_d = 1'b0;
        end
        OpSetTime: begin
          pos_d      = delta[31] ? 32'sd0 : delta;
          finished_d = 1'b0;
        end
        OpSetClip: begin
          clip_d     = clip_in;
          finished_d = 1'b0;
          clr        = 1'b1;
        end
        OpSetLoop: begin
          loop_d = item_q.loop_request;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.tick_add) begin
      pos_d = pos_t;
      if (blending) begin
        src_pos_d = src_t;
        belap_d   = el_t;
        if (el_t >= blen_q) begin
          clr = 1'b1;
        end
      end
      if (dur <= 32'sd0) begin
        if (pos_t < 32'sd0) begin
          pos_d = '0;
        end
      end else if (loop_q) begin
        // The wrap itself is finished by the divider.
        finished_d = 1'b0;
      end else if (!speed_q[15] && (pos_t >= dur)) begin
        pos_d      = dur;
        playing_d  = 1'b0;
        finished_d = 1'b1;
      end else if (speed_q[15] && (pos_t <= 32'sd0)) begin
        pos_d      = '0;
        playing_d  = 1'b0;
        finished_d = 1'b1;
      end
    end

    if (cmd_i.rem_apply) begin
      // Truncating remainder, folded into the range zero to duration.
      if (!neg_q) begin
        pos_d = rem_q;
      end else if (rem_q == '0) begin
        pos_d = '0;
      end else begin
        pos_d = dur - $signed(rem_q);
      end
    end

    if (clr) begin
      src_clip_d = '0;
      src_pos_d  = '0;
      blen_d     = '0;
      belap_d    = '0;
      src_loop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q    <= SpeedReset;
      pos_q      <= '0;
      playing_q  <= 1'b0;
      finished_q <= 1'b0;
      loop_q     <= 1'b0;
      clip_q     <= '0;
      src_clip_q <= '0;
      src_pos_q  <= '0;
      src_loop_q <= 1'b1;
      blen_q     <= '0;
      belap_q    <= '0;
    end else begin
      speed_q    <= speed_d;
      pos_q      <= pos_d;
      playing_q  <= playing_d;
      finished_q <= finished_d;
      loop_q     <= loop_d;
      clip_q     <= clip_d;
      src_clip_q <= src_clip_d;
      src_pos_q  <= src_pos_d;
      src_loop_q <= src_loop_d;
      blen_q     <= blen_d;
      belap_q    <= belap_d;
    end
  end

  // Shared restoring divider, one quotient bit per cycle.
  logic [32:0] trial;
  logic [32:0] trial_diff;
  logic        trial_ge;

  assign trial      = {rem_q, dvd_q[31]};
  assign trial_diff = trial - {1'b0, div_q};
  assign trial_ge   = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.mul) begin
      prod_q <= delta * speed_q;
    end
    if (cmd_i.rem_start) begin
      dvd_q <= pos_q[31] ? (~pos_q + 32'd1) : pos_q;
      neg_q <= pos_q[31];
      rem_q <= '0;
      div_q <= dur;
      cnt_q <= RemSteps;
    end else if (cmd_i.wgt_start) begin
      wfrac_q <= !stat_o.wgt_direct;
      dvd_q   <= '0;
      rem_q   <= elap_pos;
      div_q   <= blen_q;
      cnt_q   <= FracSteps;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_diff[31:0] : trial[31:0];
      dvd_q <= {dvd_q[30:0], 1'b0};
      quo_q <= {quo_q[14:0], trial_ge};
      cnt_q <= cnt_q - 5'd1;
    end
    if (cmd_i.out_load) begin
      out_q.time_out          <= pos_q;
      out_q.playing_out       <= playing_q;
      out_q.finished_out      <= finished_q;
      out_q.transitioning_out <= blending;
      out_q.blend_weight      <= wfrac_q ? {1'b0, quo_q} : WeightOne;
      out_q.source_clip_out   <= src_clip_q;
      out_q.source_time_out   <= src_pos_q;
      out_q.source_loop_out   <= src_loop_q;
      out_q.clip_out          <= clip_q;
      out_q.loop_out          <= loop_q;
    end
  end

  assign out_item_o = out_q;

endmodule
`default_nettype wire

### rtl/clip_playback_clock_with_crossfade_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clip playback clock with crossfade
// Keeps an animation clip position, applies one command per item and returns
// one result item with position, flags and crossfade weight.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns exactly one result item for
// each. A non-tick command passes through decode, the weight load step and
// the emit step before its result enters the output register. When a
// crossfade is in progress the blend weight is also produced by the
// shared restoring divider at one bit per cycle for a 16-bit fraction. A
// tick while playing adds a multiply and an update step, and in loop mode
// with a positive duration the 32-bit remainder on the same divider. The
// next item can be taken in the cycle after its result enters the output
// register, even while that result still waits to be taken. The speed
// register may be written with speed_we_i whenever the block is idle; it
// resets to 256 (normal speed, Q8.8).
module clip_playback_clock_with_crossfade_core
  import cpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              speed_we_i,
  input  logic signed [15:0] speed_i
);

  cmd_t  cmd;
  stat_t stat;

  // The controller owns the handshakes and the sequence of steps.
  cpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds all playback state and the arithmetic.
  cpc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_item_i  (in_item_i),
    .speed_we_i (speed_we_i),
    .speed_i    (speed_i),
    .out_item_o (out_item_o)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an item");

  // While fading, the weight stays strictly below one.
  a_weight_fading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.transitioning_out |->
      out_item_o.blend_weight < WeightOne)
    else $error("blend weight reached one during a crossfade");

  // Without a crossfade the weight is one and no source clip is shown.
  a_weight_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.transitioning_out |->
      out_item_o.blend_weight == WeightOne && out_item_o.source_clip_out == '0)
    else $error("idle crossfade state is inconsistent");
`endif

endmodule
`default_nettype wire
